// ===== src/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants, types and the CORDIC arctangent table for the
// predictive roll search core.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

	localparam int ROLLOUT_STEPS = 15;
	localparam int SEARCH_ROUNDS = 9;
	localparam int STEP_W        = $clog2(ROLLOUT_STEPS + 1);
	localparam int ROUND_W       = $clog2(SEARCH_ROUNDS + 1);

	localparam int TWO_PI_Q12   = 25736;
	localparam int PI_Q12       = 12868;
	localparam int HALF_PI_Q12  = 6434;
	localparam int DT_Q16       = 6554;
	localparam int GDT_Q20      = 1028653;
	localparam int CORDIC_K_Q14 = 9949;
	localparam int CORDIC_ITERS = 16;

	// Angles in Q4.12 with headroom for one wrap, CORDIC outputs in Q2.14.
	typedef logic signed [17:0] ang_t;
	typedef logic signed [17:0] trig_t;
	typedef logic signed [39:0] pos_t;
	typedef logic [48:0]        cost_t;
	typedef logic [1:0]         reg_idx_t;

	localparam cost_t COST_MAX  = 49'h0_FFFF_FFFF_FFFF;
	localparam cost_t COST_INIT = 49'h1_0000_0000_0000;

	localparam reg_idx_t REG_MAX_ROLL_RATE     = 2'd0;
	localparam reg_idx_t REG_SEARCH_HALF_WIDTH = 2'd1;
	localparam reg_idx_t REG_STOP_WIDTH        = 2'd2;
	localparam reg_idx_t REG_MIN_SPEED         = 2'd3;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
		logic signed [20:0] r;
		unique case (i)
			4'd0:  r = 21'sd51472;
			4'd1:  r = 21'sd30386;
			4'd2:  r = 21'sd16055;
			4'd3:  r = 21'sd8150;
			4'd4:  r = 21'sd4091;
			4'd5:  r = 21'sd2047;
			4'd6:  r = 21'sd1024;
			4'd7:  r = 21'sd512;
			4'd8:  r = 21'sd256;
			4'd9:  r = 21'sd128;
			4'd10: r = 21'sd64;
			4'd11: r = 21'sd32;
			4'd12: r = 21'sd16;
			4'd13: r = 21'sd8;
			4'd14: r = 21'sd4;
			4'd15: r = 21'sd2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/predictive_roll_search_core.sv =====
// ----------------------------------------------------------------------------
// predictive_roll_search_core
// Bisection search over the roll command, each candidate costed by a
// fixed-step kinematic rollout on one shared multiplier, CORDIC and divider.
// ----------------------------------------------------------------------------
// Usage: an input item (vehicle state and target) is taken when in_valid is
// high and in_stall is low. in_stall stays high from acceptance until the
// result has been loaded into the output register, so one item is worked on
// at a time. The result item roll_command is held with out_valid until a
// cycle with out_stall low; the next input can be taken while it waits.
// Each rollout step makes two 16-iteration CORDIC runs, a divide for the
// turn rate (skipped when its denominator is zero) and nine passes through
// the shared multiplier. A rollout is at most ROLLOUT_STEPS steps and an
// item runs at most SEARCH_ROUNDS + 2 rollouts, fewer when a rollout or
// the bisection stops early.
// The configuration port is always ready; write it only while idle.
// Reset restores the register defaults and leaves the block idle with no
// result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module predictive_roll_search_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  pos_x,
	input  wire signed [31:0]  pos_y,
	input  wire        [15:0]  speed,
	input  wire signed [31:0]  target_x,
	input  wire signed [31:0]  target_y,
	input  wire signed [15:0]  roll_now,
	input  wire signed [15:0]  heading_now,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [15:0] roll_command,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  prs_pkg::reg_idx_t  cfg_index,
	input  wire        [15:0]  cfg_data
);
	import prs_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SETUP = 5'd1;
	localparam logic [4:0] S_ROLL  = 5'd2;
	localparam logic [4:0] S_PHI   = 5'd3;
	localparam logic [4:0] S_CW1   = 5'd4;
	localparam logic [4:0] S_M1    = 5'd5;
	localparam logic [4:0] S_M2    = 5'd6;
	localparam logic [4:0] S_M3    = 5'd7;
	localparam logic [4:0] S_DW    = 5'd8;
	localparam logic [4:0] S_PSI   = 5'd9;
	localparam logic [4:0] S_CW2   = 5'd10;
	localparam logic [4:0] S_M4    = 5'd11;
	localparam logic [4:0] S_M5    = 5'd12;
	localparam logic [4:0] S_M6    = 5'd13;
	localparam logic [4:0] S_M7    = 5'd14;
	localparam logic [4:0] S_M8    = 5'd15;
	localparam logic [4:0] S_C1    = 5'd16;
	localparam logic [4:0] S_C2    = 5'd17;
	localparam logic [4:0] S_C3    = 5'd18;
	localparam logic [4:0] S_RDONE = 5'd19;
	localparam logic [4:0] S_ROUND = 5'd20;
	localparam logic [4:0] S_OUT   = 5'd21;

	localparam logic [1:0] PH_A   = 2'd0;
	localparam logic [1:0] PH_B   = 2'd1;
	localparam logic [1:0] PH_RND = 2'd2;

	logic [4:0]  state_q;
	logic [14:0] max_roll_rate_q, search_half_width_q, stop_width_q;
	logic [15:0] min_speed_q;

	logic signed [31:0] px0_q, py0_q, tx_q, ty_q;
	logic signed [15:0] phi0_q, psi0_q;
	logic [15:0]        v_q;

	logic signed [15:0] a_q, b_q, cmd_q, best_out_q, roll_q;
	cost_t              ca_q, cb_q, best_q, d2x_q;
	logic [1:0]         phase_q;
	logic               tgt_a_q;
	logic [ROUND_W-1:0] round_q;
	logic [STEP_W-1:0]  step_q;

	ang_t               phi_q, psi_q, dpsi_q;
	pos_t               px_q, py_q;
	logic signed [36:0] num_q;
	logic               nneg_q, satx_q, saty_q, out_valid_q;

	logic signed [33:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [58:0] prod_q;

	logic  cor_start, cor_done, div_start, div_done, div_sat;
	ang_t  cor_ang;
	trig_t cor_sin, cor_cos;
	logic [14:0] div_quo;

	logic signed [18:0] delta_raw, lim;
	logic signed [15:0] delta_c;
	ang_t               phi_new;
	logic signed [33:0] den_c;
	logic [32:0]        den_mag;
	logic signed [36:0] num_f, an;
	logic [36:0]        div_num;
	logic signed [18:0] psum;
	logic signed [40:0] dd;
	logic [40:0]        dmag;
	logic [32:0]        dm;
	cost_t              d2y, d2sum, d2;
	logic [14:0]        q_sat;
	logic [15:0]        v_floor;
	logic signed [16:0] sum_ab, w_raw;
	logic signed [15:0] mid, new_a, new_b;
	logic [16:0]        w_mag;
	logic               less, nstop;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign roll_command = roll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_roll_rate_q     <= 15'd3575;
			search_half_width_q <= 15'd3217;
			stop_width_q        <= 15'd410;
			min_speed_q         <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_ROLL_RATE:     max_roll_rate_q     <= cfg_data[14:0];
				REG_SEARCH_HALF_WIDTH: search_half_width_q <= cfg_data[14:0];
				REG_STOP_WIDTH:        stop_width_q        <= cfg_data[14:0];
				REG_MIN_SPEED:         min_speed_q         <= cfg_data;
			endcase
		end
	end

	always_comb begin
		v_floor = (speed < min_speed_q) ? min_speed_q : speed;
		if (v_floor == 16'd0) begin
			v_floor = 16'd1;
		end

		delta_raw = 19'(cmd_q) - 19'(phi_q);
		lim       = $signed({4'b0, max_roll_rate_q});
		if (delta_raw > lim) begin
			delta_c = 16'(lim);
		end else if (delta_raw < -lim) begin
			delta_c = 16'(-lim);
		end else begin
			delta_c = 16'(delta_raw);
		end
		phi_new = phi_q + 18'((prod_q + 59'sd32768) >>> 16);

		// Turn rate: make the denominator positive, round half away from zero.
		den_c   = 34'(prod_q);
		num_f   = (den_c < 0) ? -num_q : num_q;
		den_mag = (den_c < 0) ? 33'(-den_c) : 33'(den_c);
		an      = (num_f < 0) ? -num_f : num_f;
		div_num = 37'(an) + 37'(den_mag >> 1);
		if (div_sat || div_quo > 15'(TWO_PI_Q12)) begin
			q_sat = 15'(TWO_PI_Q12);
		end else begin
			q_sat = div_quo;
		end

		psum = 19'(psi_q) + 19'(dpsi_q);
		if (psum > 19'(TWO_PI_Q12)) begin
			psum = psum - 19'(TWO_PI_Q12);
		end else if (psum < -19'(TWO_PI_Q12)) begin
			psum = psum + 19'(TWO_PI_Q12);
		end

		if (state_q == S_C1) begin
			dd = 41'(tx_q) - 41'(px_q);
		end else begin
			dd = 41'(ty_q) - 41'(py_q);
		end
		dmag = (dd < 0) ? 41'(-dd) : 41'(dd);
		dm   = 33'(dmag >> 8);

		d2y   = saty_q ? COST_MAX : {1'b0, prod_q[47:0]};
		d2sum = d2x_q + d2y;
		d2    = (d2sum > COST_MAX) ? COST_MAX : d2sum;

		sum_ab = 17'(a_q) + 17'(b_q);
		mid    = 16'(sum_ab >>> 1);
		less   = (ca_q < cb_q);
		new_a  = less ? a_q : mid;
		new_b  = less ? mid : b_q;
		w_raw  = 17'(new_b) - 17'(new_a);
		w_mag  = (w_raw < 0) ? 17'(-w_raw) : 17'(w_raw);
		nstop  = (w_mag < {2'b0, stop_width_q});
	end

	// Operand select for the shared multiplier; the product is registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ROLL: begin
				mul_a = 34'(delta_c);
				mul_b = 25'(DT_Q16);
			end
			S_M1, S_M6: begin
				mul_a = 34'(cor_sin);
				mul_b = (state_q == S_M1) ? 25'(GDT_Q20) : $signed({9'b0, v_q});
			end
			S_M2, S_M4: begin
				mul_a = 34'(cor_cos);
				mul_b = $signed({9'b0, v_q});
			end
			S_M5, S_M7: begin
				mul_a = prod_q[33:0];
				mul_b = 25'(DT_Q16);
			end
			S_C1, S_C2: begin
				mul_a = $signed({10'b0, dm[23:0]});
				mul_b = $signed({1'b0, dm[23:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign cor_start = (state_q == S_PHI) || (state_q == S_PSI);
	assign cor_ang   = (state_q == S_PHI) ? phi_new : psi_q;
	assign div_start = (state_q == S_M3) && (den_mag != 33'd0);

	prs_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.ang     (cor_ang),
		.done    (cor_done),
		.sin_out (cor_sin),
		.cos_out (cor_cos)
	);

	prs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_mag),
		.done   (div_done),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			phase_q     <= PH_A;
			round_q     <= '0;
			step_q      <= '0;
		end else begin
			// In S_OUT the load below decides the flag on its own.
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_A;
						round_q <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					step_q  <= '0;
					state_q <= S_ROLL;
				end
				S_ROLL: state_q <= S_PHI;
				S_PHI:  state_q <= S_CW1;
				S_CW1:  if (cor_done) state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_M3;
				S_M3:   state_q <= (den_mag == 33'd0) ? S_PSI : S_DW;
				S_DW:   if (div_done) state_q <= S_PSI;
				S_PSI:  state_q <= S_CW2;
				S_CW2:  if (cor_done) state_q <= S_M4;
				S_M4:   state_q <= S_M5;
				S_M5:   state_q <= S_M6;
				S_M6:   state_q <= S_M7;
				S_M7:   state_q <= S_M8;
				S_M8:   state_q <= S_C1;
				S_C1:   state_q <= S_C2;
				S_C2:   state_q <= S_C3;
				S_C3: begin
					step_q <= step_q + 1'b1;
					if (d2 > best_q || step_q == STEP_W'(ROLLOUT_STEPS - 1)) begin
						state_q <= S_RDONE;
					end else begin
						state_q <= S_ROLL;
					end
				end
				S_RDONE: begin
					if (phase_q == PH_A) begin
						phase_q <= PH_B;
						state_q <= S_SETUP;
					end else begin
						phase_q <= PH_RND;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (round_q == ROUND_W'(SEARCH_ROUNDS)) begin
						state_q <= S_OUT;
					end else begin
						round_q <= round_q + 1'b1;
						state_q <= nstop ? S_OUT : S_SETUP;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					px0_q      <= pos_x;
					py0_q      <= pos_y;
					tx_q       <= target_x;
					ty_q       <= target_y;
					phi0_q     <= roll_now;
					psi0_q     <= heading_now;
					v_q        <= v_floor;
					a_q        <= -$signed({1'b0, search_half_width_q});
					b_q        <= $signed({1'b0, search_half_width_q});
					cmd_q      <= -$signed({1'b0, search_half_width_q});
					best_out_q <= '0;
				end
			end
			S_SETUP: begin
				phi_q  <= 18'(phi0_q);
				psi_q  <= 18'(psi0_q);
				px_q   <= 40'(px0_q);
				py_q   <= 40'(py0_q);
				best_q <= COST_INIT;
			end
			S_PHI: phi_q <= phi_new;
			S_M2:  num_q <= 37'(prod_q);
			S_M3: begin
				nneg_q <= (num_f < 0);
				if (num_f > 0) begin
					dpsi_q <= 18'(TWO_PI_Q12);
				end else if (num_f < 0) begin
					dpsi_q <= -18'(TWO_PI_Q12);
				end else begin
					dpsi_q <= '0;
				end
			end
			S_DW: begin
				if (div_done) begin
					dpsi_q <= nneg_q ? -$signed({3'b0, q_sat}) : $signed({3'b0, q_sat});
				end
			end
			S_PSI: psi_q <= 18'(psum);
			S_M6:  px_q <= px_q + 40'((prod_q + 59'sd2097152) >>> 22);
			S_M8:  py_q <= py_q + 40'((prod_q + 59'sd2097152) >>> 22);
			S_C1:  satx_q <= |dm[32:24];
			S_C2: begin
				d2x_q  <= satx_q ? COST_MAX : {1'b0, prod_q[47:0]};
				saty_q <= |dm[32:24];
			end
			S_C3: begin
				if (d2 < best_q) begin
					best_q <= d2;
				end
			end
			S_RDONE: begin
				unique case (phase_q)
					PH_A: begin
						ca_q  <= best_q;
						cmd_q <= b_q;
					end
					PH_B: cb_q <= best_q;
					default: begin
						if (tgt_a_q) begin
							ca_q <= best_q;
						end else begin
							cb_q <= best_q;
						end
					end
				endcase
			end
			S_ROUND: begin
				if (round_q != ROUND_W'(SEARCH_ROUNDS)) begin
					a_q        <= new_a;
					b_q        <= new_b;
					best_out_q <= less ? a_q : b_q;
					tgt_a_q    <= !less;
					cmd_q      <= mid;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					roll_q <= best_out_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_SETUP))
		else $error("accepted item did not start a rollout");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (den_mag != 33'd0))
		else $error("divider started with zero denominator");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q <= ROUND_W'(SEARCH_ROUNDS)))
		else $error("bisection round count out of range");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> (state_q == S_OUT))
		else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== src/prs_cordic.sv =====
// ----------------------------------------------------------------------------
// prs_cordic
// Iterative rotation CORDIC: sine and cosine of a Q4.12 angle, one
// micro-rotation per cycle after range reduction and folding.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_cordic (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  prs_pkg::ang_t  ang,
	output logic           done,
	output prs_pkg::trig_t sin_out,
	output prs_pkg::trig_t cos_out
);
	import prs_pkg::*;

	logic signed [18:0] r0, r1, r2;
	logic               neg_c;
	trig_t              x_q, y_q, xs, ys;
	logic signed [20:0] z_q;
	logic [3:0]         i_q;
	logic               busy_q, done_q, neg_q;

	// The input never exceeds two turns, so one subtraction gives the
	// truncating remainder.
	always_comb begin
		r0 = 19'(ang);
		if (r0 >= 19'(TWO_PI_Q12)) begin
			r0 = r0 - 19'(TWO_PI_Q12);
		end else if (r0 <= -19'(TWO_PI_Q12)) begin
			r0 = r0 + 19'(TWO_PI_Q12);
		end
		r1 = r0;
		if (r1 > 19'(PI_Q12)) begin
			r1 = r1 - 19'(TWO_PI_Q12);
		end
		if (r1 < -19'(PI_Q12)) begin
			r1 = r1 + 19'(TWO_PI_Q12);
		end
		r2    = r1;
		neg_c = 1'b0;
		if (r2 > 19'(HALF_PI_Q12)) begin
			r2    = r2 - 19'(PI_Q12);
			neg_c = 1'b1;
		end else if (r2 < -19'(HALF_PI_Q12)) begin
			r2    = r2 + 19'(PI_Q12);
			neg_c = 1'b1;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 4'd1;
			if (i_q == 4'(CORDIC_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 18'(CORDIC_K_Q14);
			y_q   <= '0;
			z_q   <= 21'(r2) <<< 4;
			neg_q <= neg_c;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(i_q);
			end
		end
	end

	assign done    = done_q;
	assign sin_out = neg_q ? -y_q : y_q;
	assign cos_out = neg_q ? -x_q : x_q;

endmodule

`default_nettype wire

// ===== src/prs_div.sv =====
// ----------------------------------------------------------------------------
// prs_div
// Restoring divider for the turn rate: fifteen quotient bits, one per
// cycle, with a flag for quotients that do not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [36:0] num,
	input  wire  [32:0] den,
	output logic        done,
	output logic [14:0] quo,
	output logic        sat
);
	import prs_pkg::*;

	logic [36:0] rem_q;
	logic [47:0] dsh_q;
	logic [14:0] quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q, done_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd14) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= {11'b0, num} >= {den, 15'b0};
			rem_q <= num;
			dsh_q <= {1'b0, den, 14'b0};
			quo_q <= '0;
		end else if (busy_q) begin
			if ({11'b0, rem_q} >= dsh_q) begin
				rem_q <= rem_q - dsh_q[36:0];
				quo_q <= {quo_q[13:0], 1'b1};
			end else begin
				quo_q <= {quo_q[13:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule

`default_nettype wire
